// ===== rtl/fmo_pkg.sv =====
`timescale 1ns / 1ps
// fmo_pkg: shared types, codes, constants and the quarter-wave sine table of the fm operator
package fmo_pkg;

    // phase and sine table geometry
    localparam int PHASE_BITS      = 24;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
    localparam int QTR_SIZE        = 1 << QTR_BITS;
    localparam int X_SHIFT         = 30 - QTR_BITS;

    // fixed field widths
    localparam int PINC_W    = 24;
    localparam int PMOD_W    = 24;
    localparam int COEFF_W   = 16;
    localparam int VEL_W     = 16;
    localparam int ENV_W     = 17;
    localparam int SAMPLE_W  = 16;
    localparam int SINE_MAG_W = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OP_W      = 2;

    // shared multiplier widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // envelope constants, Q1.16
    localparam logic [ENV_W-1:0] FULL_SCALE  = 17'd65536;
    localparam logic [ENV_W-1:0] ATTACK_DONE = 17'd65471;
    localparam logic [ENV_W-1:0] NEAR_LIMIT  = 17'd65;

    // largest output magnitude
    localparam logic [SAMPLE_W-1:0] MAG_MAX = 16'd32767;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEVEL = 3'd5;

    // sin(pi/2 * x) series coefficients, Q30
    localparam logic [63:0] SK1 = 64'd1686629713;
    localparam logic [63:0] SK3 = 64'd693598669;
    localparam logic [63:0] SK5 = 64'd85569306;
    localparam logic [63:0] SK7 = 64'd5026995;
    localparam logic [63:0] SK9 = 64'd172272;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_env_stage;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENV,
        S_ENVU,
        S_M1,
        S_M2,
        S_M3L,
        S_M3H,
        S_SUM
    } t_state;

    typedef struct packed {
        logic                  neg;
        logic [SINE_MAG_W-1:0] mag;
    } t_sine;

    typedef logic [SINE_MAG_W-1:0] t_sine_tab [QTR_SIZE];

    // sin(pi/2 * x), x and result in Q30
    function automatic logic [63:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        x2 = (x * x) >> 30;
        p  = SK9;
        p  = SK7 - ((x2 * p) >> 30);
        p  = SK5 - ((x2 * p) >> 30);
        p  = SK3 - ((x2 * p) >> 30);
        p  = SK1 - ((x2 * p) >> 30);
        return (x * p) >> 30;
    endfunction

    // Q30 argument to rounded and limited Q15 magnitude
    function automatic logic [SINE_MAG_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0] r;
        r = (quarter_sine(x) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[SINE_MAG_W-1:0];
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        for (int i = 0; i < QTR_SIZE; i++) begin
            tab[i] = sine_entry(64'(i) << X_SHIFT);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();
    localparam logic [SINE_MAG_W-1:0] SINE_PEAK = sine_entry(64'd1 << 30);

endpackage

// ===== rtl/fmo_mul.sv =====
`timescale 1ns / 1ps
// fmo_mul: shared 32 by 16 unsigned multiplier with registered product
module fmo_mul
    import fmo_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_prod;

    // one product per cycle, available the cycle after issue
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_prod;

endmodule

// ===== rtl/fmo_sine.sv =====
`timescale 1ns / 1ps
// fmo_sine: registered quarter-wave sine lookup with quadrant folding
module fmo_sine
    import fmo_pkg::*;
(
    input  logic                  i_clk,
    input  logic [PHASE_BITS-1:0] i_phase,
    output t_sine                 o_sine
);

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [QTR_BITS-1:0]        f;
    logic [QTR_BITS-1:0]        f_rev;
    t_sine                      n_sine;
    t_sine                      r_sine;

    // top bits of the phase pick quadrant and table offset
    assign idx   = i_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad  = idx[SINE_TABLE_BITS-1 -: 2];
    assign f     = idx[QTR_BITS-1:0];
    assign f_rev = ~f + QTR_BITS'(1);

    // falling quadrants read the table backward, the very top is the peak
    always_comb begin
        n_sine.neg = quad[1];
        if (quad[0]) begin
            if (f == '0) begin
                n_sine.mag = SINE_PEAK;
            end else begin
                n_sine.mag = SINE_TAB[f_rev];
            end
        end else begin
            n_sine.mag = SINE_TAB[f];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine <= n_sine;
    end

    assign o_sine = r_sine;

endmodule

// ===== rtl/fm_operator_with_envelope.sv =====
`timescale 1ns / 1ps
// fm_operator_with_envelope: top level of one fm operator with adsr envelope
// One FM operator: note-on and note-off beats and idle ticks (envelope at rest)
// are done as they are taken; a tick while a note sounds passes through the states
// S_ENV, S_ENVU, S_M1, S_M2, S_M3L, S_M3H and S_SUM to the output register, since
// the one 32x16 multiplier is used five times in turn (envelope step, sine times
// envelope, times output level, and the two halves of the velocity product), so no
// beat is taken until such a tick is done. The input is stalled while a tick is
// being worked on and while a finished sample waits in the output register and the
// output side stalls; a waiting sample keeps every kind of beat out until it is taken.
module fm_operator_with_envelope
    import fmo_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [OP_W-1:0]              i_op,
    input  logic [VEL_W-1:0]             i_velocity,
    input  logic signed [PMOD_W-1:0]     i_phase_mod,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [SAMPLE_W-1:0]   o_sample,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // configuration registers
    logic [PINC_W-1:0]   r_phase_inc;
    logic [COEFF_W-1:0]  r_attack;
    logic [COEFF_W-1:0]  r_decay;
    logic [COEFF_W-1:0]  r_release;
    logic [ENV_W-1:0]    r_sustain;
    logic [COEFF_W-1:0]  r_out_level;

    // operator state
    t_state              r_state;
    t_state              n_state;
    t_env_stage          r_stage;
    t_env_stage          n_stage;
    logic [ENV_W-1:0]    r_env;
    logic [ENV_W-1:0]    n_env;
    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [VEL_W-1:0]    r_velocity;

    // working registers
    logic [PMOD_W-1:0]   r_mod;
    logic [VEL_W-1:0]    r_hi;
    logic [MUL_P_W-1:0]  r_acc;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_sample;

    // datapath
    logic                in_acc;
    logic                out_free;
    logic [32:0]         mod_ext;
    logic [32:0]         inc_ext;
    logic [PHASE_BITS-1:0] phase_sum;
    t_sine               sine;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  prod;
    logic [ENV_W-1:0]    sus;
    logic [ENV_W-1:0]    tgt;
    logic                up;
    logic [ENV_W-1:0]    diff;
    logic [COEFF_W-1:0]  coeff;
    logic [ENV_W-1:0]    step;
    logic [ENV_W-1:0]    env_new;
    logic [ENV_W-1:0]    dec_dist;
    logic [63:0]         total;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] mag_sat;
    logic [SAMPLE_W-1:0] n_sample;

    // handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // phase with modulation, wrapped to one turn
    assign mod_ext   = {{(33 - PMOD_W){r_mod[PMOD_W-1]}}, r_mod};
    assign inc_ext   = {{(33 - PINC_W){1'b0}}, r_phase_inc};
    assign phase_sum = r_phase_acc + mod_ext[PHASE_BITS-1:0];

    fmo_sine u_sine (
        .i_clk   (i_clk),
        .i_phase (phase_sum),
        .o_sine  (sine)
    );

    // envelope target and distance for the current stage
    assign sus = (r_sustain > FULL_SCALE) ? FULL_SCALE : r_sustain;

    always_comb begin
        case (r_stage)
            ST_ATTACK: begin
                tgt   = FULL_SCALE;
                coeff = r_attack;
            end
            ST_DECAY: begin
                tgt   = sus;
                coeff = r_decay;
            end
            ST_RELEASE: begin
                tgt   = '0;
                coeff = r_release;
            end
            default: begin
                tgt   = sus;
                coeff = '0;
            end
        endcase
    end

    assign up   = tgt >= r_env;
    assign diff = up ? (tgt - r_env) : (r_env - tgt);
    assign step = prod[COEFF_W +: ENV_W];
    assign env_new  = up ? (r_env + step) : (r_env - step);
    assign dec_dist = (env_new >= sus) ? (env_new - sus) : (sus - env_new);

    // envelope step result and stage change
    always_comb begin
        n_env   = env_new;
        n_stage = r_stage;
        case (r_stage)
            ST_ATTACK: begin
                if (env_new >= ATTACK_DONE) begin
                    n_env   = FULL_SCALE;
                    n_stage = ST_DECAY;
                end
            end
            ST_DECAY: begin
                if (dec_dist <= NEAR_LIMIT) begin
                    n_env   = sus;
                    n_stage = ST_SUSTAIN;
                end
            end
            ST_SUSTAIN: begin
                n_env = sus;
            end
            ST_RELEASE: begin
                if (env_new <= NEAR_LIMIT) begin
                    n_env   = '0;
                    n_stage = ST_IDLE;
                end
            end
            default: begin
                n_env   = '0;
                n_stage = ST_IDLE;
            end
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_ENV: begin
                mul_a = MUL_A_W'(diff);
                mul_b = coeff;
            end
            S_M1: begin
                mul_a = MUL_A_W'(r_env);
                mul_b = MUL_B_W'(sine.mag);
            end
            S_M2: begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = r_out_level;
            end
            S_M3L: begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = r_velocity;
            end
            S_M3H: begin
                mul_a = MUL_A_W'(r_hi);
                mul_b = r_velocity;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fmo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // combine the velocity halves, keep the top 16 bits, saturate and sign
    assign total    = {prod[31:0], 32'd0} + {16'd0, r_acc};
    assign mag      = total[63:48];
    assign mag_sat  = (mag > MAG_MAX) ? MAG_MAX : mag;
    assign n_sample = sine.neg ? (SAMPLE_W'(0) - mag_sat) : mag_sat;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_op == OP_TICK) && (r_stage != ST_IDLE)) begin
                    n_state = S_ENV;
                end
            end
            S_ENV:  n_state = S_ENVU;
            S_ENVU: n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3L;
            S_M3L:  n_state = S_M3H;
            S_M3H:  n_state = S_SUM;
            S_SUM: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_attack    <= '0;
            r_decay     <= '0;
            r_release   <= '0;
            r_sustain   <= '0;
            r_out_level <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PHASE_INC: r_phase_inc <= PINC_W'(i_cfg_data);
                REG_ATTACK:    r_attack    <= i_cfg_data[COEFF_W-1:0];
                REG_DECAY:     r_decay     <= i_cfg_data[COEFF_W-1:0];
                REG_RELEASE:   r_release   <= i_cfg_data[COEFF_W-1:0];
                REG_SUSTAIN:   r_sustain   <= i_cfg_data[ENV_W-1:0];
                REG_OUT_LEVEL: r_out_level <= i_cfg_data[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // operator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_env       <= '0;
            r_phase_acc <= '0;
            r_velocity  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_op)
                            OP_NOTE_ON: begin
                                r_velocity  <= i_velocity;
                                r_stage     <= ST_ATTACK;
                                r_env       <= '0;
                                r_phase_acc <= '0;
                            end
                            OP_NOTE_OFF: begin
                                if (r_stage != ST_IDLE) begin
                                    r_stage <= ST_RELEASE;
                                end
                            end
                            OP_TICK: begin
                                if (r_stage == ST_IDLE) begin
                                    r_env       <= '0;
                                    r_out_valid <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ENVU: begin
                    r_env   <= n_env;
                    r_stage <= n_stage;
                end
                S_SUM: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_phase_acc <= r_phase_acc + inc_ext[PHASE_BITS-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_acc) begin
            r_mod <= i_phase_mod;
            if (i_op == OP_TICK) begin
                r_sample <= '0;
            end
        end
        if (r_state == S_M3L) begin
            r_hi <= prod[MUL_P_W-1 -: VEL_W];
        end
        if (r_state == S_M3H) begin
            r_acc <= prod;
        end
        if ((r_state == S_SUM) && out_free) begin
            r_sample <= n_sample;
        end
    end

    // checks
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input accepted while a tick is in progress");

    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= FULL_SCALE)
        else $error("envelope above full scale");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_IDLE) |-> (r_env == '0))
        else $error("idle stage with nonzero envelope");

    a_sum_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) && out_free) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished tick did not reach the output register");

endmodule
